// ----- src/tiir_pkg.sv -----
// ----------------------------------------------------------------------------
// tiir_pkg: shared constants and types for the third-order IIR tone filter
// Coefficient format, register indexes and default parameter values.
// ----------------------------------------------------------------------------
package tiir_pkg;

    // Coefficient format: signed Q4.28
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 28;
    localparam int NUM_COEF  = 7;
    localparam int CFG_IDX_W = 3;

    // Unity gain in Q4.28, reset value of the current-input gain
    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    // Defaults for the top-level parameters
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_SAMPLE_BITS = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } coef_idx_t;

endpackage

// ----- src/third_order_iir_tone_filter_core.sv -----
// ----------------------------------------------------------------------------
// third_order_iir_tone_filter_core: multichannel third-order IIR filter
// Direct-form-I filter with per-channel input and output history held in a
// synchronous memory, Q4.28 coefficients, rounding and saturation.
//
//  Channel   Direction  Handshake               Payload
//  s_        in         s_tvalid / s_tready     s_tdata sample, s_tuser channel
//  m_        out        m_tvalid / m_tready     m_tdata sample, m_tuser channel
//  cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data (coefficient)
//
// An accepted word passes through history read and capture, then seven
// products, two partial sums, and final sum with round and saturate before
// it reaches the output register.
// One word is accepted per cycle while the output is not stalled and each
// word names a channel other than those of the three words before it; a
// word for a channel that is still in flight waits for its history
// write-back, so one channel alone or two alternating channels run slower.
// Reset loads the coefficient defaults and clears the per-row valid bits of
// the history memory, so all history reads as zero with no clearing pass.
// A stall on m_tready holds the output register and fills the stages behind
// it one by one before s_tready drops.
// ----------------------------------------------------------------------------
module third_order_iir_tone_filter_core
    import tiir_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  logic                 s_tuser,   // [0] channel
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    output logic                 m_tuser,   // [0] channel_out
    // coefficient writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - COEF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [SH_W-1:0]  SAT_MAX =
        {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SH_W-1:0]  SAT_MIN =
        {{(SH_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef struct packed {
        smp_t x0;
        smp_t x1;
        smp_t x2;
        smp_t y0;
        smp_t y1;
        smp_t y2;
    } hist_row_t;

    // ------------------------------------------------------------------------
    // coefficient registers
    // ------------------------------------------------------------------------
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                coef_reg[k] <= (k == int'(REG_B0)) ? COEF_ONE : '0;
            end
        end else if (cfg_valid) begin
            unique case (coef_idx_t'(cfg_index))
                REG_B0:  coef_reg[REG_B0] <= cfg_data;
                REG_B1:  coef_reg[REG_B1] <= cfg_data;
                REG_B2:  coef_reg[REG_B2] <= cfg_data;
                REG_B3:  coef_reg[REG_B3] <= cfg_data;
                REG_A1:  coef_reg[REG_A1] <= cfg_data;
                REG_A2:  coef_reg[REG_A2] <= cfg_data;
                REG_A3:  coef_reg[REG_A3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------------
    logic             v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, in_idx;
    logic             ch1_reg, ch2_reg, ch3_reg, m_ch_reg;
    logic             out_rdy, rdy3, rdy2, rdy1;
    logic             go1, go2, go3, s_accept, hazard;

    assign in_idx = (CHANNELS > 1) ? IDX_W'(s_tuser) : '0;

    // advance each stage when the one after it is free or moving
    assign out_rdy = !m_valid_reg || m_tready;
    assign go3     = v3_reg && out_rdy;
    assign rdy3    = !v3_reg || out_rdy;
    assign go2     = v2_reg && rdy3;
    assign rdy2    = !v2_reg || rdy3;
    assign go1     = v1_reg && rdy2;
    assign rdy1    = !v1_reg || rdy2;

    // hold a word whose channel history is still being updated
    assign hazard = (v1_reg && idx1_reg == in_idx) ||
                    (v2_reg && idx2_reg == in_idx) ||
                    (v3_reg && idx3_reg == in_idx);

    assign s_tready = rdy1 && !hazard;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_accept;
            if (rdy2) v2_reg <= go1;
            if (rdy3) v3_reg <= go2;
            if (out_rdy) m_valid_reg <= go3;
        end
    end

    // ------------------------------------------------------------------------
    // history memory: one row per channel, read at accept, written at stage 3
    // ------------------------------------------------------------------------
    hist_row_t              hist_mem [CHANNELS];
    logic [CHANNELS-1:0]    row_vld_reg;
    hist_row_t              rd_row_reg, row1, wr_row;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_row_reg <= hist_mem[in_idx];
        end
        if (go3) begin
            hist_mem[idx3_reg] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (s_accept) rd_vld_reg <= row_vld_reg[in_idx];
            if (go3) row_vld_reg[idx3_reg] <= 1'b1;
        end
    end

    // a row never written reads as zero
    assign row1 = rd_vld_reg ? rd_row_reg : '0;

    // ------------------------------------------------------------------------
    // stage 1: capture the word
    // ------------------------------------------------------------------------
    smp_t x1_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x1_reg   <= s_tdata[SAMPLE_BITS-1:0];
            ch1_reg  <= s_tuser;
            idx1_reg <= in_idx;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: seven products, shifted history for write-back
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg [NUM_COEF];
    hist_row_t                hist2_reg, hist3_reg;

    always_ff @(posedge aclk) begin
        if (go1) begin
            prod_reg[REG_B0] <= PROD_W'(coef_reg[REG_B0]) * PROD_W'(x1_reg);
            prod_reg[REG_B1] <= PROD_W'(coef_reg[REG_B1]) * PROD_W'(row1.x0);
            prod_reg[REG_B2] <= PROD_W'(coef_reg[REG_B2]) * PROD_W'(row1.x1);
            prod_reg[REG_B3] <= PROD_W'(coef_reg[REG_B3]) * PROD_W'(row1.x2);
            prod_reg[REG_A1] <= PROD_W'(coef_reg[REG_A1]) * PROD_W'(row1.y0);
            prod_reg[REG_A2] <= PROD_W'(coef_reg[REG_A2]) * PROD_W'(row1.y1);
            prod_reg[REG_A3] <= PROD_W'(coef_reg[REG_A3]) * PROD_W'(row1.y2);
            hist2_reg.x0     <= x1_reg;
            hist2_reg.x1     <= row1.x0;
            hist2_reg.x2     <= row1.x1;
            hist2_reg.y0     <= '0;
            hist2_reg.y1     <= row1.y0;
            hist2_reg.y2     <= row1.y1;
            ch2_reg          <= ch1_reg;
            idx2_reg         <= idx1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: feedforward and feedback partial sums, rounding offset
    // ------------------------------------------------------------------------
    logic signed [ACC_W-1:0] ff_reg, fb_reg;

    always_ff @(posedge aclk) begin
        if (go2) begin
            ff_reg    <= ACC_W'(prod_reg[REG_B0]) + ACC_W'(prod_reg[REG_B1]) +
                         ACC_W'(prod_reg[REG_B2]) + ACC_W'(prod_reg[REG_B3]);
            fb_reg    <= ROUND_HALF - ACC_W'(prod_reg[REG_A1]) -
                         ACC_W'(prod_reg[REG_A2]) - ACC_W'(prod_reg[REG_A3]);
            hist3_reg <= hist2_reg;
            ch3_reg   <= ch2_reg;
            idx3_reg  <= idx2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // final sum, scale down, saturate
    // ------------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [SH_W-1:0]  acc_sh;
    smp_t                    y_sat;

    always_comb begin
        acc_sum = ff_reg + fb_reg;
        acc_sh  = acc_sum[ACC_W-1:COEF_FRAC];
        priority if (acc_sh > SAT_MAX) begin
            y_sat = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (acc_sh < SAT_MIN) begin
            y_sat = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_sh[SAMPLE_BITS-1:0];
        end
        wr_row    = hist3_reg;
        wr_row.y0 = y_sat;
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    smp_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (go3) begin
            m_data_reg <= y_sat;
            m_ch_reg   <= ch3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'($unsigned(m_data_reg));
    assign m_tuser  = m_ch_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_same_row_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !((v1_reg && v2_reg && idx1_reg == idx2_reg) ||
          (v1_reg && v3_reg && idx1_reg == idx3_reg) ||
          (v2_reg && v3_reg && idx2_reg == idx3_reg)))
        else $error("two words of one channel in flight together");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !out_rdy) |=> (v3_reg && $stable(idx3_reg) && $stable(ff_reg)))
        else $error("stage 3 word lost under stall");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        go3 |=> (m_valid_reg && m_tuser == $past(ch3_reg)))
        else $error("finished word not in output register");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for third_order_iir_tone_filter_core
// Drives samples with random channel and content through the stream ports.
// Every accepted word is run through a bit-exact software filter that keeps
// its own per-channel history and coefficient copy. The expected words are
// queued, and each returned word is compared against the oldest one.
// Coefficients are rewritten between phases, only while the filter is empty.
// Both sides idle at random. One phase holds the result side off for a long
// stretch so the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import tiir_pkg::*;

    localparam int CHANNELS    = DEF_CHANNELS;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 16;
    localparam int PHASE_WORDS = 103;
    localparam int HOLD_CYCLES = 300;

    // register index past the end of the coefficient list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_W-1:0]      COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]      COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]      COEF_HALF  = 32'h0800_0000;

    typedef enum int {
        GAINS_SMALL,
        GAINS_FULL,
        GAINS_EXTREME,
        GAINS_ECHO
    } gain_mix_t;

    typedef enum int {
        CH_RANDOM,
        CH_ALTERNATE,
        CH_SINGLE
    } chan_mix_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   channel;
    } filtered_t;

    // ------------------------------------------------------------------------
    // Scoreboard: bit-exact filter step plus queue of words still due
    // ------------------------------------------------------------------------
    class tone_filter_score;
        logic signed [COEF_W-1:0]      gain [NUM_COEF];
        logic signed [SAMPLE_BITS-1:0] x_hist [CHANNELS][3];
        logic signed [SAMPLE_BITS-1:0] y_hist [CHANNELS][3];
        filtered_t                     filtered_due [$];
        int                            err_count;

        function new();
            foreach (gain[i]) gain[i] = '0;
            gain[REG_B0] = COEF_ONE;
            foreach (x_hist[c, k]) begin
                x_hist[c][k] = '0;
                y_hist[c][k] = '0;
            end
            err_count = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            if (idx < NUM_COEF) begin
                gain[idx] = val;
            end
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction

        // run one sample through the filter and queue the result
        function void note_sample(logic [SAMPLE_BITS-1:0] x_raw, logic ch);
            logic signed [SAMPLE_BITS-1:0] x;
            logic signed [63:0]            acc;
            logic signed [63:0]            rounded;
            logic signed [SAMPLE_BITS-1:0] y;
            int                            c;
            filtered_t                     due;
            x = x_raw;
            c = ch % CHANNELS;
            acc = gain[REG_B0] * x
                + gain[REG_B1] * x_hist[c][0]
                + gain[REG_B2] * x_hist[c][1]
                + gain[REG_B3] * x_hist[c][2]
                - gain[REG_A1] * y_hist[c][0]
                - gain[REG_A2] * y_hist[c][1]
                - gain[REG_A3] * y_hist[c][2];
            // round half up, then clamp to the sample range
            rounded = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (rounded > $signed({{(64-SAMPLE_BITS){1'b0}}, SAMPLE_MAX})) begin
                y = SAMPLE_MAX;
            end else if (rounded < $signed({{(64-SAMPLE_BITS){1'b1}}, SAMPLE_MIN})) begin
                y = SAMPLE_MIN;
            end else begin
                y = rounded[SAMPLE_BITS-1:0];
            end
            // advance the channel's delay lines
            x_hist[c][2] = x_hist[c][1];
            x_hist[c][1] = x_hist[c][0];
            x_hist[c][0] = x;
            y_hist[c][2] = y_hist[c][1];
            y_hist[c][1] = y_hist[c][0];
            y_hist[c][0] = y;
            due.sample  = y;
            due.channel = ch;
            filtered_due.push_back(due);
        endfunction

        task report(string what);
            $display("tb: mismatch at %0t: %s", $realtime, what);
            err_count++;
        endtask

        task check_filtered(logic [SAMPLE_BITS-1:0] got, logic got_ch);
            filtered_t due;
            if (filtered_due.size() == 0) begin
                report($sformatf("word %h ch %0d with nothing due", got, got_ch));
            end else begin
                due = filtered_due.pop_front();
                if (got !== due.sample) begin
                    report($sformatf("sample %h, due %h", got, due.sample));
                end
                if (got_ch !== due.channel) begin
                    report($sformatf("channel %0d, due %0d", got_ch, due.channel));
                end
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;   // [SAMPLE_BITS-1:0] sample_in
    logic                 s_tuser;   // [0] channel
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;   // [SAMPLE_BITS-1:0] sample_out
    logic                 m_tuser;   // [0] channel_out
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    tone_filter_score sb;
    int               tx_idle_pct;
    int               rx_stall_pct;
    int               rx_hold_left;
    int               cycle_count;

    third_order_iir_tone_filter_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(7) == 0) return $urandom_range(60, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        int                     pick;
        int                     span;
        logic [SAMPLE_BITS-1:0] v;
        pick = $urandom_range(7);
        if (pick == 0) begin
            case ($urandom_range(3))
                0:       v = SAMPLE_MAX;
                1:       v = SAMPLE_MIN;
                2:       v = '0;
                default: v = '1;
            endcase
        end else if (pick < 4) begin
            v = SAMPLE_BITS'($urandom);
        end else begin
            // small amplitudes keep the feedback paths out of saturation
            span = $urandom_range(20, 4);
            v = SAMPLE_BITS'($urandom_range((1 << (span + 1)) - 1) - (1 << span));
        end
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] pick_gain(gain_mix_t mix);
        logic [COEF_W-1:0] v;
        case (mix)
            GAINS_SMALL: v = COEF_W'($urandom_range(1 << 27) - (1 << 26));
            GAINS_FULL:  v = $urandom;
            default: begin
                case ($urandom_range(3))
                    0:       v = COEF_MAX;
                    1:       v = COEF_MIN;
                    2:       v = '0;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // offer one word after a random gap, hold it until accepted
    task automatic send_sample(logic [SAMPLE_BITS-1:0] x, logic ch);
        int gap;
        gap = idle_len(tx_idle_pct);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(x);
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(x, ch);
    endtask

    // drop valid and wait until every due word has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_gain(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, long hold on request, check every word
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = idle_len(rx_stall_pct);
                if (stall_left == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_filtered(m_tdata[SAMPLE_BITS-1:0], m_tuser);
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        gain_mix_t mix;
        chan_mix_t chan_mix;
        logic      ch;
        sb           = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // unity gain after reset: full-scale, zero, and toggling patterns
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h555555, 1'b1);
        send_sample(24'hAAAAAA, 1'b1);

        // largest positive gain: overflow saturates both ways
        wait_drained();
        write_coef(REG_B0, COEF_MAX);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(24'h000001, 1'b0);

        // most negative gain flips the saturation
        wait_drained();
        write_coef(REG_B0, COEF_MIN);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);

        // half gain: exact halves round toward plus infinity
        wait_drained();
        write_coef(REG_B0, COEF_HALF);
        send_sample(24'h000001, 1'b0);
        send_sample('1, 1'b0);
        send_sample(24'h000003, 1'b1);
        send_sample(24'hFFFFFD, 1'b1);

        // write past the register list must leave the gains alone
        wait_drained();
        write_coef(REG_UNUSED, COEF_MAX);
        send_sample(24'h000005, 1'b0);

        // strong positive feedback runs the output into saturation
        wait_drained();
        write_coef(REG_B0, COEF_ONE);
        write_coef(REG_A1, COEF_MIN);
        write_coef(REG_B3, COEF_MAX);
        repeat (4) send_sample(24'h000064, 1'b1);

        // random phases, each with its own gains, idling and channel mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            mix = gain_mix_t'(p % 4);
            for (int r = 0; r < NUM_COEF; r++) begin
                if (mix == GAINS_ECHO) begin
                    write_coef(CFG_IDX_W'(r), (r == REG_B0) ? COEF_ONE :
                                  (r == REG_A1) ? pick_gain(GAINS_SMALL) : '0);
                end else begin
                    write_coef(CFG_IDX_W'(r), pick_gain(mix));
                end
            end
            if ($urandom_range(1) == 1) begin
                write_coef(REG_UNUSED, $urandom);
            end
            chan_mix     = chan_mix_t'(p % 3);
            tx_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(60, 10);
            rx_stall_pct = (p % 5 == 1) ? 0 : $urandom_range(60, 10);
            if (p == 5) begin
                // back-pressure: result side holds while words keep coming
                tx_idle_pct  = 0;
                rx_hold_left = HOLD_CYCLES;
            end
            ch = 1'($urandom_range(1));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                case (chan_mix)
                    CH_RANDOM:    ch = 1'($urandom_range(1));
                    CH_ALTERNATE: ch = ~ch;
                    default:      ch = ch;
                endcase
                send_sample(next_sample(), ch);
            end
        end

        // collect the tail, then wait for stray words
        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
